[src/dtpc_pkg.sv]
// Shared constants, types and the division step function for the point cloud pipeline.
`default_nettype none

package dtpc_pkg;

  // Image and field geometry
  localparam int MAX_DIM   = 4096;
  localparam int COORD_W   = 12;
  localparam int DISP_W    = 8;
  localparam int COLOR_W   = 8;
  localparam int REG_W     = 24;
  localparam int OFFS_W    = 17;
  localparam int POINT_W   = 32;
  localparam int FRAC_BITS = 8;

  // Arithmetic widths
  localparam int DIFF_W          = REG_W + 2;
  localparam int PROD_W          = 2 * REG_W;
  localparam int DIV_W           = PROD_W - FRAC_BITS;
  localparam int STEPS_PER_STAGE = 8;
  localparam int DIV_STAGES      = DIV_W / STEPS_PER_STAGE;

  // Lanes of the divider
  localparam int LANES  = 3;
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  // Configuration register map
  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FOCAL        = 3'd0,
    REG_BASELINE     = 3'd1,
    REG_CENTER_COL   = 3'd2,
    REG_CENTER_ROW   = 3'd3,
    REG_MIN_DISP     = 3'd4,
    REG_DEPTH_OFFSET = 3'd5
  } cfg_reg_t;

  localparam logic [REG_W-1:0]         FOCAL_RST        = REG_W'(256000);
  localparam logic [REG_W-1:0]         BASELINE_RST     = REG_W'(256);
  localparam logic [REG_W-1:0]         CENTER_RST       = '0;
  localparam logic [DISP_W-1:0]        MIN_DISP_RST     = DISP_W'(3);
  localparam logic signed [OFFS_W-1:0] DEPTH_OFFSET_RST = OFFS_W'(1500);

  typedef struct packed {
    logic [REG_W-1:0]         focal;
    logic [REG_W-1:0]         baseline;
    logic [REG_W-1:0]         center_col;
    logic [REG_W-1:0]         center_row;
    logic [DISP_W-1:0]        min_disp;
    logic signed [OFFS_W-1:0] depth_offset;
  } cfg_t;

  // One division lane: dividend shifts out at the top, quotient shifts in at the bottom
  typedef struct packed {
    logic              neg;
    logic [DIV_W-1:0]  num;
    logic [DISP_W-1:0] rem;
  } lane_t;

  typedef struct packed {
    lane_t [LANES-1:0]  lane;
    logic [DISP_W-1:0]  disp;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } item_t;

  // Run one stage worth of restoring division steps on a lane
  function automatic lane_t div_steps(lane_t l, logic [DISP_W-1:0] d);
    logic [DISP_W:0] r9;
    lane_t           o;
    o = l;
    for (int i = 0; i < STEPS_PER_STAGE; i++) begin
      r9 = {o.rem, o.num[DIV_W-1]};
      if (r9 >= {1'b0, d}) begin
        o.rem = DISP_W'(r9 - {1'b0, d});
        o.num = {o.num[DIV_W-2:0], 1'b1};
      end else begin
        o.rem = r9[DISP_W-1:0];
        o.num = {o.num[DIV_W-2:0], 1'b0};
      end
    end
    return o;
  endfunction

endpackage

`default_nettype wire

[src/dtpc_cfg.sv]
// Configuration register file of the point cloud pipeline.
`default_nettype none

module dtpc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [dtpc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [dtpc_pkg::REG_W-1:0]     cfg_data,
  output dtpc_pkg::cfg_t                      cfg
);
  import dtpc_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  // Take every write; unknown indexes fall through
  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_FOCAL:        cfg_nxt.focal        = cfg_data;
        REG_BASELINE:     cfg_nxt.baseline     = cfg_data;
        REG_CENTER_COL:   cfg_nxt.center_col   = cfg_data;
        REG_CENTER_ROW:   cfg_nxt.center_row   = cfg_data;
        REG_MIN_DISP:     cfg_nxt.min_disp     = cfg_data[DISP_W-1:0];
        REG_DEPTH_OFFSET: cfg_nxt.depth_offset = $signed(cfg_data[OFFS_W-1:0]);
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.focal        <= FOCAL_RST;
      cfg_r.baseline     <= BASELINE_RST;
      cfg_r.center_col   <= CENTER_RST;
      cfg_r.center_row   <= CENTER_RST;
      cfg_r.min_disp     <= MIN_DISP_RST;
      cfg_r.depth_offset <= DEPTH_OFFSET_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

[src/dtpc_front.sv]
// Front stages: pixel filter, offset from the principal point, baseline products.
`default_nettype none

module dtpc_front (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire dtpc_pkg::cfg_t               cfg,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [dtpc_pkg::COORD_W-1:0] in_pixel_row,
  input  wire logic [dtpc_pkg::COORD_W-1:0] in_pixel_col,
  input  wire logic [dtpc_pkg::DISP_W-1:0]  in_disparity,
  input  wire logic [dtpc_pkg::COLOR_W-1:0] in_red_in,
  input  wire logic [dtpc_pkg::COLOR_W-1:0] in_green_in,
  input  wire logic [dtpc_pkg::COLOR_W-1:0] in_blue_in,
  output logic                              valid_o,
  output dtpc_pkg::item_t                   item_o,
  input  wire logic                         ready_i
);
  import dtpc_pkg::*;

  logic              keep;
  logic signed [DIFF_W-1:0] diff_x;
  logic signed [DIFF_W-1:0] diff_y;
  logic              ready_a;
  logic              ready_b;

  logic              a_valid_r, a_valid_nxt;
  logic              a_neg_x_r, a_neg_y_r;
  logic [REG_W-1:0]  a_mag_x_r, a_mag_y_r;
  logic [DISP_W-1:0] a_disp_r;
  logic [COLOR_W-1:0] a_red_r, a_green_r, a_blue_r;

  logic [PROD_W-1:0] prod_x, prod_y, prod_z;
  logic              b_valid_r, b_valid_nxt;
  item_t             b_item_r, b_item_nxt;

  // Drop zero, small and out-of-image pixels at the door
  assign keep = (in_disparity != '0) && (in_disparity >= cfg.min_disp)
             && (32'(in_pixel_row) < 32'(MAX_DIM)) && (32'(in_pixel_col) < 32'(MAX_DIM));

  // Signed offset from the principal point, split into sign and magnitude
  assign diff_x = $signed(DIFF_W'(cfg.center_col)) - $signed(DIFF_W'({in_pixel_col, FRAC_BITS'(0)}));
  assign diff_y = $signed(DIFF_W'(cfg.center_row)) - $signed(DIFF_W'({in_pixel_row, FRAC_BITS'(0)}));

  assign ready_a     = !a_valid_r || ready_b;
  assign a_valid_nxt = ready_a ? (in_valid && keep) : a_valid_r;
  assign in_ready    = ready_a;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  // Load stage A on every input transfer
  always_ff @(posedge clk) begin
    if (ready_a && in_valid) begin
      a_neg_x_r <= diff_x[DIFF_W-1];
      a_neg_y_r <= diff_y[DIFF_W-1];
      a_mag_x_r <= REG_W'(diff_x[DIFF_W-1] ? -diff_x : diff_x);
      a_mag_y_r <= REG_W'(diff_y[DIFF_W-1] ? -diff_y : diff_y);
      a_disp_r  <= in_disparity;
      a_red_r   <= in_red_in;
      a_green_r <= in_green_in;
      a_blue_r  <= in_blue_in;
    end
  end

  // Stage B: scale by the baseline and drop the fraction of the dividend
  assign prod_x = a_mag_x_r * cfg.baseline;
  assign prod_y = a_mag_y_r * cfg.baseline;
  assign prod_z = cfg.focal * cfg.baseline;

  always_comb begin
    b_item_nxt                 = b_item_r;
    b_item_nxt.lane[LANE_X].neg = a_neg_x_r;
    b_item_nxt.lane[LANE_X].num = prod_x[PROD_W-1:FRAC_BITS];
    b_item_nxt.lane[LANE_X].rem = '0;
    b_item_nxt.lane[LANE_Y].neg = a_neg_y_r;
    b_item_nxt.lane[LANE_Y].num = prod_y[PROD_W-1:FRAC_BITS];
    b_item_nxt.lane[LANE_Y].rem = '0;
    b_item_nxt.lane[LANE_Z].neg = 1'b0;
    b_item_nxt.lane[LANE_Z].num = prod_z[PROD_W-1:FRAC_BITS];
    b_item_nxt.lane[LANE_Z].rem = '0;
    b_item_nxt.disp            = a_disp_r;
    b_item_nxt.red             = a_red_r;
    b_item_nxt.green           = a_green_r;
    b_item_nxt.blue            = a_blue_r;
  end

  assign ready_b     = !b_valid_r || ready_i;
  assign b_valid_nxt = ready_b ? a_valid_r : b_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else begin
      b_valid_r <= b_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_b && a_valid_r) begin
      b_item_r <= b_item_nxt;
    end
  end

  assign valid_o = b_valid_r;
  assign item_o  = b_item_r;

`ifndef SYNTHESIS
  // A pixel of zero disparity never enters the pipeline
  a_drop_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_disparity == '0) |=> !a_valid_r)
    else $error("zero disparity pixel entered stage A");
`endif

endmodule

`default_nettype wire

[src/dtpc_div_stage.sv]
// One divider stage: eight restoring division steps on each of the three lanes.
`default_nettype none

module dtpc_div_stage (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            valid_i,
  input  wire dtpc_pkg::item_t item_i,
  output logic                 ready_o,
  output logic                 valid_o,
  output dtpc_pkg::item_t      item_o,
  input  wire logic            ready_i
);
  import dtpc_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;

  // Advance every lane by one stage of quotient bits
  always_comb begin
    item_nxt = item_i;
    for (int l = 0; l < LANES; l++) begin
      item_nxt.lane[l] = div_steps(item_i.lane[l], item_i.disp);
    end
  end

  assign ready_o   = !valid_r || ready_i;
  assign valid_nxt = ready_o ? valid_i : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      item_r <= item_nxt;
    end
  end

  assign valid_o = valid_r;
  assign item_o  = item_r;

`ifndef SYNTHESIS
  // Partial remainders stay below the divisor
  a_rem_below_disp: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r |-> (item_r.lane[LANE_X].rem < item_r.disp)
             && (item_r.lane[LANE_Y].rem < item_r.disp)
             && (item_r.lane[LANE_Z].rem < item_r.disp))
    else $error("division remainder not below disparity");

  // A stalled stage keeps its item
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !ready_i) |=> (valid_r && $stable(item_r)))
    else $error("divider stage lost or changed a stalled item");
`endif

endmodule

`default_nettype wire

[src/dtpc_back.sv]
// Output stage: sign, depth offset, saturation and the result register.
`default_nettype none

module dtpc_back (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire dtpc_pkg::cfg_t               cfg,
  input  wire logic                         valid_i,
  input  wire dtpc_pkg::item_t              item_i,
  output logic                              ready_o,
  output logic                              out_valid,
  input  wire logic                         out_ready,
  output logic signed [dtpc_pkg::POINT_W-1:0] out_point_x,
  output logic signed [dtpc_pkg::POINT_W-1:0] out_point_y,
  output logic signed [dtpc_pkg::POINT_W-1:0] out_point_z,
  output logic [dtpc_pkg::COLOR_W-1:0]      out_red_out,
  output logic [dtpc_pkg::COLOR_W-1:0]      out_green_out,
  output logic [dtpc_pkg::COLOR_W-1:0]      out_blue_out
);
  import dtpc_pkg::*;

  localparam int ZW = DIV_W + 2;
  localparam logic [DIV_W-1:0]     Q_POS_MAX = DIV_W'(64'h7FFF_FFFF);
  localparam logic [DIV_W-1:0]     Q_NEG_MAX = DIV_W'(64'h8000_0000);
  localparam logic signed [ZW-1:0] Z_MAX     = ZW'(64'sh7FFF_FFFF);
  localparam logic signed [ZW-1:0] Z_MIN     = -Z_MAX - ZW'(1);
  localparam logic signed [POINT_W-1:0] P_MAX = {1'b0, {(POINT_W-1){1'b1}}};
  localparam logic signed [POINT_W-1:0] P_MIN = {1'b1, {(POINT_W-1){1'b0}}};

  // Apply the sign to a lateral quotient and clamp to 32 bits
  function automatic logic signed [POINT_W-1:0] sat_lateral(lane_t l);
    logic [DIV_W-1:0] q;
    q = l.num;
    if (!l.neg) begin
      return (q > Q_POS_MAX) ? P_MAX : POINT_W'(q);
    end else begin
      return (q > Q_NEG_MAX) ? P_MIN : POINT_W'(-q);
    end
  endfunction

  logic signed [ZW-1:0]      z_full;
  logic signed [POINT_W-1:0] z_sat;
  logic                      out_valid_r, out_valid_nxt;
  logic signed [POINT_W-1:0] x_r, y_r, z_r;
  logic [COLOR_W-1:0]        red_r, green_r, blue_r;

  // Depth minus the offset in whole units
  assign z_full = $signed(ZW'(item_i.lane[LANE_Z].num))
                - ZW'($signed({cfg.depth_offset, FRAC_BITS'(0)}));

  always_comb begin
    priority if (z_full > Z_MAX) begin
      z_sat = P_MAX;
    end else if (z_full < Z_MIN) begin
      z_sat = P_MIN;
    end else begin
      z_sat = POINT_W'(z_full);
    end
  end

  assign ready_o       = !out_valid_r || out_ready;
  assign out_valid_nxt = ready_o ? valid_i : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      x_r     <= sat_lateral(item_i.lane[LANE_X]);
      y_r     <= sat_lateral(item_i.lane[LANE_Y]);
      z_r     <= z_sat;
      red_r   <= item_i.red;
      green_r <= item_i.green;
      blue_r  <= item_i.blue;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_point_x   = x_r;
  assign out_point_y   = y_r;
  assign out_point_z   = z_r;
  assign out_red_out   = red_r;
  assign out_green_out = green_r;
  assign out_blue_out  = blue_r;

endmodule

`default_nettype wire

[src/disparity_to_point_cloud.sv]
// Top level of the stereo disparity to colored 3D point pipeline.
//
// Takes one pixel per clock while the output does not stall and returns its colored
// 3D point in signed Q23.8, or nothing for a pixel of zero disparity or of disparity
// below min_disparity. A pixel passes one stage for the pixel filter and the offset
// from the principal point, one for the baseline multipliers, five divider stages
// that produce the 40-bit quotient by the disparity eight bits at a time, and the
// output register with sign, depth offset and saturation. Stalls on the output
// propagate stage by stage, so empty stages keep filling while a result waits. The
// user is to write registers through the cfg port only while no pixel is in flight;
// the block does not enforce this. The cfg port is always ready.
`default_nettype none

module disparity_to_point_cloud (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [dtpc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [dtpc_pkg::REG_W-1:0]       cfg_data,
  input  wire logic                             in_valid,
  output logic                                  in_ready,
  input  wire logic [dtpc_pkg::COORD_W-1:0]     in_pixel_row,
  input  wire logic [dtpc_pkg::COORD_W-1:0]     in_pixel_col,
  input  wire logic [dtpc_pkg::DISP_W-1:0]      in_disparity,
  input  wire logic [dtpc_pkg::COLOR_W-1:0]     in_red_in,
  input  wire logic [dtpc_pkg::COLOR_W-1:0]     in_green_in,
  input  wire logic [dtpc_pkg::COLOR_W-1:0]     in_blue_in,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic signed [dtpc_pkg::POINT_W-1:0]   out_point_x,
  output logic signed [dtpc_pkg::POINT_W-1:0]   out_point_y,
  output logic signed [dtpc_pkg::POINT_W-1:0]   out_point_z,
  output logic [dtpc_pkg::COLOR_W-1:0]          out_red_out,
  output logic [dtpc_pkg::COLOR_W-1:0]          out_green_out,
  output logic [dtpc_pkg::COLOR_W-1:0]          out_blue_out
);
  import dtpc_pkg::*;

  cfg_t  cfg;
  logic  [DIV_STAGES:0] stg_valid;
  logic  [DIV_STAGES:0] stg_ready;
  item_t stg_item [DIV_STAGES+1];

  // Configuration registers
  dtpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Filter and multiply
  dtpc_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel_row (in_pixel_row),
    .in_pixel_col (in_pixel_col),
    .in_disparity (in_disparity),
    .in_red_in    (in_red_in),
    .in_green_in  (in_green_in),
    .in_blue_in   (in_blue_in),
    .valid_o      (stg_valid[0]),
    .item_o       (stg_item[0]),
    .ready_i      (stg_ready[0])
  );

  // Divider chain
  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
    dtpc_div_stage u_div (
      .clk     (clk),
      .rst_n   (rst_n),
      .valid_i (stg_valid[s]),
      .item_i  (stg_item[s]),
      .ready_o (stg_ready[s]),
      .valid_o (stg_valid[s+1]),
      .item_o  (stg_item[s+1]),
      .ready_i (stg_ready[s+1])
    );
  end

  // Sign, offset, saturation and result register
  dtpc_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .valid_i       (stg_valid[DIV_STAGES]),
    .item_i        (stg_item[DIV_STAGES]),
    .ready_o       (stg_ready[DIV_STAGES]),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_point_x   (out_point_x),
    .out_point_y   (out_point_y),
    .out_point_z   (out_point_z),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out)
  );

`ifndef SYNTHESIS
  // With the sink ready, the whole pipeline moves and the input is open
  a_ready_chain: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input blocked while output side is ready");
`endif

endmodule

`default_nettype wire
